[rtl/awwf_pkg.sv]
package awwf_pkg;

   localparam int HISTORY_DEPTH = 128;
   localparam int MAX_WINDOW    = 100;

   localparam int SAMPLE_W  = 23;
   localparam int WIN_W     = 7;
   localparam int THR_W     = 16;
   localparam int DIFF_W    = SAMPLE_W + 1;
   localparam int PTR_W     = $clog2(HISTORY_DEPTH);
   localparam int CNT_W     = $clog2(HISTORY_DEPTH + 1);
   localparam int SUM_W     = SAMPLE_W + WIN_W;
   localparam int MAG_W     = SUM_W - 1;
   localparam int DIV_CNT_W = $clog2(MAG_W + 1);
   localparam int DATA_W    = ((SAMPLE_W + 7) / 8) * 8;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic signed [SAMPLE_W-1:0] HEAVY_LIMIT = SAMPLE_W'(1800000);
   localparam logic signed [SAMPLE_W-1:0] LIGHT_LIMIT = SAMPLE_W'(100000);
   localparam int SHORT_LAG    = 10;
   localparam int LONG_LAG     = 30;
   localparam int SHORT_MOTION = 20;
   localparam int LONG_MOTION  = 30;
   localparam int HEAVY_JUMP   = 30;
   localparam int STEP_LOW     = 10;
   localparam int STEP_HIGH    = 30;

   localparam logic [THR_W-1:0] JUMP_THRESHOLD_RESET = THR_W'(10);
   localparam logic [WIN_W-1:0] WINDOW_LIMIT_RESET   = WIN_W'(10);

   typedef enum logic [1:0] {
      REG_JUMP_THRESHOLD = 2'd0,
      REG_WINDOW_LIMIT   = 2'd1,
      REG_LONG_LAG_MODE  = 2'd2
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LAG_A,
      ST_LAG_B,
      ST_EVAL,
      ST_SUM,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic rd_lag10;
      logic rd_lag30;
      logic cap_lag10;
      logic eval;
      logic sum_rd;
      logic div_init;
      logic div_step;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic sum_done;
      logic div_done;
      logic out_free;
   } dp_status_type;

   typedef struct packed {
      logic [THR_W-1:0] jump_threshold;
      logic [WIN_W-1:0] window_limit;
      logic             long_lag_mode;
   } cfg_type;

endpackage

[rtl/awwf_ctrl.sv]
module awwf_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  awwf_pkg::dp_status_type   status,
   output awwf_pkg::dp_cmd_type      cmd
);
   import awwf_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_LAG_A;
         end
         ST_LAG_A: state_in = ST_LAG_B;
         ST_LAG_B: state_in = ST_EVAL;
         ST_EVAL:  state_in = ST_SUM;
         ST_SUM: begin
            if (status.sum_done) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_LAG_A: cmd.rd_lag10 = 1'b1;
         ST_LAG_B: begin
            cmd.rd_lag30  = 1'b1;
            cmd.cap_lag10 = 1'b1;
         end
         ST_EVAL: cmd.eval = 1'b1;
         ST_SUM: begin
            if (status.sum_done) begin
               cmd.div_init = 1'b1;
            end else begin
               cmd.sum_rd = 1'b1;
            end
         end
         ST_DIV: cmd.div_step = !status.div_done;
         ST_DONE: cmd.out_load = status.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

[rtl/awwf_datapath.sv]
module awwf_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  awwf_pkg::dp_cmd_type                  cmd,
   output awwf_pkg::dp_status_type               status,
   input  awwf_pkg::cfg_type                     cfg,
   input  logic signed [awwf_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic signed [awwf_pkg::SAMPLE_W-1:0]  rsp_filtered,
   output logic                                  rsp_motion
);
   import awwf_pkg::*;

   // history ring, newest entry at head
   logic signed [SAMPLE_W-1:0] hist_mem [HISTORY_DEPTH];

   logic [PTR_W-1:0]  head_ff, head_in, head_inc;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [PTR_W-1:0]  rd_k, rd_addr;
   logic signed [SAMPLE_W-1:0] rd_data_ff;
   logic              rd_ok_ff;
   logic signed [SAMPLE_W-1:0] rd_val;

   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic signed [SAMPLE_W-1:0] lag10_ff, lag10_in;
   logic [WIN_W-1:0]  age_ff, age_in;
   logic [WIN_W-1:0]  winlen_ff, winlen_in;
   logic              motion_ff, motion_in;

   logic signed [DIFF_W-1:0] diff10, diff30;
   logic [DIFF_W-1:0] abs10, abs30, jump_lim;
   logic              heavy, light, motion_c, jump_c;
   logic [WIN_W-1:0]  age_c, win_c;
   logic [WIN_W:0]    win_raw, wl_plus;

   logic [CNT_W-1:0]  lim_ff, lim_in;
   logic [CNT_W-1:0]  sum_idx_ff, sum_idx_in;
   logic              pend_ff, pend_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;

   logic [MAG_W-1:0]     q_ff, q_in;
   logic [WIN_W-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                 neg_ff, neg_in;
   logic [WIN_W:0]       rem_sh;
   logic                 rem_ge;
   logic [SUM_W-1:0]     sum_abs;
   logic [SAMPLE_W-1:0]  mean_c;

   logic                       out_valid_ff, out_valid_in;
   logic signed [SAMPLE_W-1:0] out_filt_ff, out_filt_in;
   logic                       out_motion_ff, out_motion_in;

   // memory
   assign head_inc = (head_ff == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : head_ff + 1'b1;

   always_comb begin
      rd_k = sum_idx_ff[PTR_W-1:0];
      if (cmd.rd_lag10) rd_k = PTR_W'(SHORT_LAG);
      if (cmd.rd_lag30) rd_k = PTR_W'(LONG_LAG);
      rd_addr = (head_ff >= rd_k) ? head_ff - rd_k : head_ff + PTR_W'(HISTORY_DEPTH) - rd_k;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) hist_mem[head_inc] <= req_sample;
      rd_data_ff <= hist_mem[rd_addr];
      rd_ok_ff   <= CNT_W'(rd_k) < fill_ff;
   end

   assign rd_val = rd_ok_ff ? rd_data_ff : '0;

   always_comb begin
      head_in = head_ff;
      fill_in = fill_ff;
      if (cmd.load) begin
         head_in = head_inc;
         if (fill_ff != CNT_W'(HISTORY_DEPTH)) fill_in = fill_ff + 1'b1;
      end
   end

   // motion, jump and window
   always_comb begin
      heavy  = sample_ff < HEAVY_LIMIT;
      light  = sample_ff > LIGHT_LIMIT;
      diff10 = {sample_ff[SAMPLE_W-1], sample_ff} - {lag10_ff[SAMPLE_W-1], lag10_ff};
      diff30 = {sample_ff[SAMPLE_W-1], sample_ff} - {rd_val[SAMPLE_W-1], rd_val};
      abs10  = diff10[DIFF_W-1] ? DIFF_W'(-diff10) : DIFF_W'(diff10);
      abs30  = diff30[DIFF_W-1] ? DIFF_W'(-diff30) : DIFF_W'(diff30);
      motion_c = heavy && (cfg.long_lag_mode ? (abs30 > DIFF_W'(LONG_MOTION))
                                             : (abs10 > DIFF_W'(SHORT_MOTION)));
      jump_lim = heavy ? DIFF_W'(cfg.jump_threshold) : DIFF_W'(HEAVY_JUMP);
      jump_c   = abs10 > jump_lim;
      if (jump_c) begin
         age_c = WIN_W'(1);
      end else if (age_ff < WIN_W'(MAX_WINDOW)) begin
         age_c = age_ff + 1'b1;
      end else begin
         age_c = age_ff;
      end
      wl_plus = {1'b0, winlen_ff} + 1'b1;
      if (light) begin
         win_raw = (age_c > cfg.window_limit) ? {1'b0, cfg.window_limit} : {1'b0, age_c};
         win_c   = win_raw[WIN_W-1:0];
      end else begin
         if (age_c < WIN_W'(STEP_LOW)) begin
            win_raw = {1'b0, age_c};
         end else if (age_c < WIN_W'(STEP_HIGH)) begin
            win_raw = (WIN_W + 1)'(STEP_LOW);
         end else begin
            win_raw = wl_plus;
         end
         win_c = (win_raw > (WIN_W + 1)'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW)
                                                      : win_raw[WIN_W-1:0];
      end
   end

   always_comb begin
      sample_in = cmd.load ? req_sample : sample_ff;
      lag10_in  = cmd.cap_lag10 ? rd_val : lag10_ff;
      age_in    = cmd.eval ? age_c : age_ff;
      winlen_in = cmd.eval ? win_c : winlen_ff;
      motion_in = cmd.eval ? motion_c : motion_ff;
      lim_in    = lim_ff;
      if (cmd.eval) begin
         lim_in = (CNT_W'(win_c) < CNT_W'(HISTORY_DEPTH)) ? CNT_W'(win_c)
                                                          : CNT_W'(HISTORY_DEPTH);
      end
   end

   // window sum, one entry per cycle
   always_comb begin
      sum_idx_in = sum_idx_ff;
      pend_in    = 1'b0;
      sum_in     = sum_ff;
      if (cmd.eval) begin
         sum_idx_in = '0;
         sum_in     = '0;
      end else begin
         if (cmd.sum_rd && (sum_idx_ff != lim_ff)) begin
            sum_idx_in = sum_idx_ff + 1'b1;
            pend_in    = 1'b1;
         end
         if (pend_ff) begin
            sum_in = sum_ff + {{(SUM_W - SAMPLE_W){rd_val[SAMPLE_W-1]}}, rd_val};
         end
      end
   end

   assign status.sum_done = (sum_idx_ff == lim_ff) && !pend_ff;

   // restoring divider on the magnitude
   always_comb begin
      sum_abs    = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      rem_sh     = {rem_ff, q_ff[MAG_W-1]};
      rem_ge     = rem_sh >= {1'b0, winlen_ff};
      q_in       = q_ff;
      rem_in     = rem_ff;
      div_cnt_in = div_cnt_ff;
      neg_in     = neg_ff;
      if (cmd.div_init) begin
         q_in       = sum_abs[MAG_W-1:0];
         rem_in     = '0;
         div_cnt_in = DIV_CNT_W'(MAG_W);
         neg_in     = sum_ff[SUM_W-1];
      end else if (cmd.div_step) begin
         q_in       = {q_ff[MAG_W-2:0], rem_ge};
         rem_in     = rem_ge ? WIN_W'(rem_sh - {1'b0, winlen_ff}) : rem_sh[WIN_W-1:0];
         div_cnt_in = div_cnt_ff - 1'b1;
      end
   end

   assign status.div_done = (div_cnt_ff == '0);

   // result register
   always_comb begin
      mean_c = q_ff[SAMPLE_W-1:0];
      if (winlen_ff == '0) begin
         out_filt_in = '0;
      end else if (neg_ff) begin
         out_filt_in = -mean_c;
      end else begin
         out_filt_in = mean_c;
      end
      out_motion_in = motion_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   assign status.out_free = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         fill_ff      <= '0;
         age_ff       <= '0;
         winlen_ff    <= '0;
         pend_ff      <= 1'b0;
         div_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         age_ff       <= age_in;
         winlen_ff    <= winlen_in;
         pend_ff      <= pend_in;
         div_cnt_ff   <= div_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff  <= sample_in;
      lag10_ff   <= lag10_in;
      motion_ff  <= motion_in;
      lim_ff     <= lim_in;
      sum_idx_ff <= sum_idx_in;
      sum_ff     <= sum_in;
      q_ff       <= q_in;
      rem_ff     <= rem_in;
      neg_ff     <= neg_in;
      if (cmd.out_load) begin
         out_filt_ff   <= out_filt_in;
         out_motion_ff <= out_motion_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_filtered = out_filt_ff;
   assign rsp_motion   = out_motion_ff;

endmodule

[rtl/adaptive_window_weight_filter_unit.sv]
// Adaptive window weight filter. Each item on req carries one signed weight sample
// (0.0001 units); each produces one item on rsp with the mean of the newest window
// samples and a motion flag. One item is processed at a time: after acceptance the
// window is summed from the single-port history memory, read one entry per cycle,
// and a bit-serial restoring divider forms the mean from its 29-bit magnitude.
// A finished result waits in an output register, so the next item is taken while
// it is pending. The user must write registers over csr only while the block is
// idle; the block itself does not enforce this.
module adaptive_window_weight_filter_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [awwf_pkg::DATA_W-1:0]         req_tdata,   // sample
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [awwf_pkg::DATA_W-1:0]         rsp_tdata,   // filtered
   output logic                                rsp_tuser,   // motion
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [awwf_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [awwf_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [awwf_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import awwf_pkg::*;

   logic [THR_W-1:0] thr_ff, thr_in;
   logic [WIN_W-1:0] wlim_ff, wlim_in;
   logic             mode_ff, mode_in;
   logic             csr_wr;
   reg_index_type    csr_idx;
   cfg_type          cfg;
   dp_cmd_type       cmd;
   dp_status_type    status;
   logic signed [SAMPLE_W-1:0] filtered;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      thr_in  = thr_ff;
      wlim_in = wlim_ff;
      mode_in = mode_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_JUMP_THRESHOLD: thr_in  = csr_pwdata[THR_W-1:0];
            REG_WINDOW_LIMIT:   wlim_in = csr_pwdata[WIN_W-1:0];
            REG_LONG_LAG_MODE:  mode_in = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_JUMP_THRESHOLD: csr_prdata = CSR_DATA_W'(thr_ff);
         REG_WINDOW_LIMIT:   csr_prdata = CSR_DATA_W'(wlim_ff);
         REG_LONG_LAG_MODE:  csr_prdata = CSR_DATA_W'(mode_ff);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= JUMP_THRESHOLD_RESET;
         wlim_ff <= WINDOW_LIMIT_RESET;
         mode_ff <= 1'b0;
      end else begin
         thr_ff  <= thr_in;
         wlim_ff <= wlim_in;
         mode_ff <= mode_in;
      end
   end

   assign cfg.jump_threshold = thr_ff;
   assign cfg.window_limit   = wlim_ff;
   assign cfg.long_lag_mode  = mode_ff;

   awwf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   awwf_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .cfg          (cfg),
      .req_sample   (req_tdata[SAMPLE_W-1:0]),
      .rsp_ready    (rsp_tready),
      .rsp_valid    (rsp_tvalid),
      .rsp_filtered (filtered),
      .rsp_motion   (rsp_tuser)
   );

   assign rsp_tdata = DATA_W'(unsigned'(filtered));

endmodule

[rtl/awwf_checker.sv]
module awwf_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [awwf_pkg::DATA_W-1:0]     rsp_tdata,
   input logic                            rsp_tuser
);
   import awwf_pkg::*;

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // one item at a time
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("item accepted while busy");

   // result does not appear right after acceptance when nothing was pending
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !rsp_tvalid) |=> !rsp_tvalid ##1 !rsp_tvalid)
      else $error("result too early");

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind adaptive_window_weight_filter_unit awwf_checker u_awwf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
